[rtl/cha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cha_pkg: shared types and constants of the compass heading unit
// Coordinate and angle widths, the CORDIC arctangent table in degrees with
// 16 fraction bits, and the pipeline word passed between the stages.
// ----------------------------------------------------------------------------
package cha_pkg;

	// Number of CORDIC iterations and the table that bounds it
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int NUM_ITER      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

	// Input words are scaled by 2^24 before the iterations
	localparam int PRESCALE_SH = 24;
	localparam int RAW_W       = 16;
	// |v| <= 2^39.5 after prescale, CORDIC gain < 1.65: 42 bits plus margin
	localparam int XW          = 43;
	// Angle in degrees with 16 fraction bits, |z| < 200 * 2^16
	localparam int FRAC_W      = 16;
	localparam int ZW          = 26;
	localparam int HEAD_W      = 9;

	// Cycles from an accepted word to its result strobe
	localparam int LATENCY = NUM_ITER + 2;

	typedef logic signed [XW-1:0] coord_t;
	typedef logic signed [ZW-1:0] angle_t;

	localparam angle_t Z90 = angle_t'(90 * (1 << FRAC_W));

	// Heading values for the axis cases and the clamp
	localparam logic [HEAD_W-1:0] DEG_90  = HEAD_W'(90);
	localparam logic [HEAD_W-1:0] DEG_180 = HEAD_W'(180);
	localparam logic [HEAD_W-1:0] DEG_270 = HEAD_W'(270);
	localparam logic [HEAD_W-1:0] DEG_359 = HEAD_W'(359);
	localparam logic [HEAD_W-1:0] DEG_360 = HEAD_W'(360);

	// One word in flight through the pipeline
	typedef struct packed {
		logic              axis;     // result settled before the iterations
		logic [HEAD_W-1:0] axis_deg;
		coord_t            x;
		coord_t            y;
		angle_t            z;
	} cha_word_t;

	// atan(2^-i) in degrees times 65536, rounded to nearest
	function automatic angle_t stage_angle(input int i);
		angle_t a;
		case (i)
			0:       a = angle_t'(2949120);
			1:       a = angle_t'(1740967);
			2:       a = angle_t'(919879);
			3:       a = angle_t'(466945);
			4:       a = angle_t'(234379);
			5:       a = angle_t'(117304);
			6:       a = angle_t'(58666);
			7:       a = angle_t'(29335);
			8:       a = angle_t'(14668);
			9:       a = angle_t'(7334);
			10:      a = angle_t'(3667);
			11:      a = angle_t'(1833);
			12:      a = angle_t'(917);
			13:      a = angle_t'(458);
			14:      a = angle_t'(229);
			15:      a = angle_t'(115);
			16:      a = angle_t'(57);
			17:      a = angle_t'(29);
			18:      a = angle_t'(14);
			19:      a = angle_t'(7);
			20:      a = angle_t'(4);
			21:      a = angle_t'(2);
			22:      a = angle_t'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

[rtl/cha_prep.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cha_prep: input stage
// Sign-extends the raw words, settles the axis cases and pre-rotates the
// vector by +-90 degrees into the right half plane.
// ----------------------------------------------------------------------------
module cha_prep (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_vld,
	input  wire logic [cha_pkg::RAW_W-1:0]       x_raw,
	input  wire logic [cha_pkg::RAW_W-1:0]       y_raw,
	output logic                                 vld_s1,
	output cha_pkg::cha_word_t                   word_s1
);

	logic signed [cha_pkg::RAW_W:0] xe, ye, xr, yr;
	cha_pkg::angle_t                 zr;
	cha_pkg::cha_word_t              word_d;

	assign xe = {x_raw[cha_pkg::RAW_W-1], x_raw};
	assign ye = {y_raw[cha_pkg::RAW_W-1], y_raw};

	// Quadrant fold: left half plane turned by +-90 degrees
	always_comb begin
		if (xe < 0) begin
			if (ye > 0) begin
				xr = ye;
				yr = -xe;
				zr = cha_pkg::Z90;
			end else begin
				xr = -ye;
				yr = xe;
				zr = -cha_pkg::Z90;
			end
		end else begin
			xr = xe;
			yr = ye;
			zr = '0;
		end
	end

	// Axis cases bypass the iterations
	always_comb begin
		word_d.axis     = 1'b0;
		word_d.axis_deg = cha_pkg::DEG_180;
		if (ye == 0) begin
			word_d.axis     = 1'b1;
			word_d.axis_deg = (xe < 0) ? cha_pkg::DEG_360 : cha_pkg::DEG_180;
		end else if (xe == 0) begin
			word_d.axis     = 1'b1;
			word_d.axis_deg = (ye > 0) ? cha_pkg::DEG_270 : cha_pkg::DEG_90;
		end
		word_d.x = cha_pkg::coord_t'(xr) <<< cha_pkg::PRESCALE_SH;
		word_d.y = cha_pkg::coord_t'(yr) <<< cha_pkg::PRESCALE_SH;
		word_d.z = zr;
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= word_d;
	end

endmodule
`default_nettype wire

[rtl/cha_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cha_cordic: vectoring iterations
// One register stage per CORDIC iteration; each stage drives y toward zero
// and accumulates the rotation angle. A stage with y already zero holds.
// ----------------------------------------------------------------------------
module cha_cordic (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                vld_s1,
	input  wire cha_pkg::cha_word_t  word_s1,
	output logic                     vld_out,
	output cha_pkg::cha_word_t       word_out
);

	localparam int N = cha_pkg::NUM_ITER;

	logic               vld_s  [N];
	cha_pkg::cha_word_t word_s [N];

	for (genvar k = 0; k < N; k++) begin : g_iter
		logic               vld_i;
		cha_pkg::cha_word_t word_i;
		cha_pkg::coord_t    dx, dy;
		cha_pkg::cha_word_t nxt;

		// Stage input: the fold register or the previous iteration
		if (k == 0) begin : g_first
			assign vld_i  = vld_s1;
			assign word_i = word_s1;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign word_i = word_s[k-1];
		end

		// Shifts round toward minus infinity
		assign dx = word_i.y >>> k;
		assign dy = word_i.x >>> k;

		// Rotate by -+atan(2^-k) depending on the sign of y
		always_comb begin
			nxt = word_i;
			if (word_i.y > 0) begin
				nxt.x = word_i.x + dx;
				nxt.y = word_i.y - dy;
				nxt.z = word_i.z + cha_pkg::stage_angle(k);
			end else if (word_i.y < 0) begin
				nxt.x = word_i.x - dx;
				nxt.y = word_i.y + dy;
				nxt.z = word_i.z - cha_pkg::stage_angle(k);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			word_s[k] <= nxt;
		end
	end

	assign vld_out  = vld_s[N-1];
	assign word_out = word_s[N-1];

endmodule
`default_nettype wire

[rtl/cha_quant.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cha_quant: output stage
// Offsets the angle by 180 degrees, floors to whole degrees, clamps to
// 0..359 but for axis words, and registers the result with its strobe.
// ----------------------------------------------------------------------------
module cha_quant (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         vld_in,
	input  wire cha_pkg::cha_word_t           word_in,
	output logic                              done_q,
	output logic [cha_pkg::HEAD_W-1:0]        heading_q
);

	localparam int SW = cha_pkg::ZW + 1;
	localparam int QW = SW - cha_pkg::FRAC_W;

	logic signed [SW-1:0]         zsum;
	logic signed [QW-1:0]         qdeg;
	logic [cha_pkg::HEAD_W-1:0]   head_d;

	// Floor of (z + 180 deg) in whole degrees
	assign zsum = SW'(word_in.z) + SW'(180 * (1 << cha_pkg::FRAC_W));
	assign qdeg = zsum[SW-1:cha_pkg::FRAC_W];

	// Clamp, axis cases take their fixed value
	always_comb begin
		if (word_in.axis) begin
			head_d = word_in.axis_deg;
		end else if (qdeg < 0) begin
			head_d = '0;
		end else if (qdeg > QW'(359)) begin
			head_d = cha_pkg::DEG_359;
		end else begin
			head_d = qdeg[cha_pkg::HEAD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		heading_q <= head_d;
	end

endmodule
`default_nettype wire

[rtl/compass_heading_atan2_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_atan2_unit: heading in degrees from raw magnetometer X/Y
//
// Input: drive x_raw and y_raw (16-bit two's complement) with start high;
// the word is taken at the clock edge where start is high and busy is low.
// busy stays low: the unit takes a new word in every cycle.
// Output: heading_deg = floor(atan2(y, x) in degrees) + 180, 0..360, is
// shown for exactly one cycle with done high, after its word has passed
// the fold, iteration and output registers; results leave in order.
// Throughput is one word per cycle: one register stage per CORDIC iteration
// plus an input fold stage and an output floor-and-clamp stage.
// The receiver cannot stall; done is a one-cycle strobe and must be taken.
// Reset (arst_n low) clears all valid bits: words in flight are dropped
// and done stays low until new words come through.
// ----------------------------------------------------------------------------
module compass_heading_atan2_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [cha_pkg::RAW_W-1:0]   x_raw,
	input  wire logic [cha_pkg::RAW_W-1:0]   y_raw,
	output logic                             done,
	output logic [cha_pkg::HEAD_W-1:0]       heading_deg
);

	logic               vld_s1, vld_it;
	cha_pkg::cha_word_t word_s1, word_it;

	// Fully pipelined: never refuses a word
	assign busy = 1'b0;

	cha_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start & ~busy),
		.x_raw   (x_raw),
		.y_raw   (y_raw),
		.vld_s1  (vld_s1),
		.word_s1 (word_s1)
	);

	cha_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.word_s1  (word_s1),
		.vld_out  (vld_it),
		.word_out (word_it)
	);

	cha_quant u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_in    (vld_it),
		.word_in   (word_it),
		.done_q    (done),
		.heading_q (heading_deg)
	);

endmodule
`default_nettype wire

[rtl/cha_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cha_checker: port-level checks of the compass heading unit
// Watches accepted words and result strobes over the pipeline latency.
// ----------------------------------------------------------------------------
module cha_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic [cha_pkg::RAW_W-1:0]   x_raw,
	input  wire logic [cha_pkg::RAW_W-1:0]   y_raw,
	input  wire logic                        done,
	input  wire logic [cha_pkg::HEAD_W-1:0]  heading_deg
);

	localparam int LAT = cha_pkg::LATENCY;

	// Every taken word gives a strobe after the fixed latency
	a_word_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("taken word produced no result strobe");

	// Heading never exceeds 360
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> heading_deg <= cha_pkg::DEG_360)
		else $error("heading out of range");

	// Zero vector gives 180
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && x_raw == '0 && y_raw == '0
		|-> ##LAT (done && heading_deg == cha_pkg::DEG_180))
		else $error("zero vector heading wrong");

	// Negative X axis gives 360
	a_neg_x: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && y_raw == '0 && x_raw[cha_pkg::RAW_W-1]
		|-> ##LAT (done && heading_deg == cha_pkg::DEG_360))
		else $error("negative X axis heading wrong");

	// Only the full-circle case reaches 360
	a_360_only_axis: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && y_raw != '0
		|-> ##LAT (done && heading_deg != cha_pkg::DEG_360))
		else $error("heading 360 off the negative X axis");

endmodule

bind compass_heading_atan2_unit cha_checker u_cha_checker (.*);
`default_nettype wire

[tb/sv/compass_heading_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_check: result checker for the compass heading unit
// Watches the command and result sides of the unit, works out the heading of
// every accepted X/Y word with its own CORDIC vectoring model, and compares
// each result strobe against the oldest heading still owed.
// ----------------------------------------------------------------------------
module compass_heading_check (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [cha_pkg::RAW_W-1:0]   x_raw,
	input  logic [cha_pkg::RAW_W-1:0]   y_raw,
	input  logic                        done,
	input  logic [cha_pkg::HEAD_W-1:0]  heading_deg,
	output int                          mismatches,
	output int                          outstanding
);

	localparam int     RAW_W     = cha_pkg::RAW_W;
	localparam int     HEAD_W    = cha_pkg::HEAD_W;
	localparam longint DEG_ONE   = 65536;
	localparam int     ATAN_ROWS = 24;

	typedef struct {
		logic [RAW_W-1:0]  x;
		logic [RAW_W-1:0]  y;
		logic [HEAD_W-1:0] heading;
	} owed_heading_t;

	owed_heading_t owed_q[$];

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic longint atan_q16(input int i);
		case (i)
			0:       return 2949120;
			1:       return 1740967;
			2:       return 919879;
			3:       return 466945;
			4:       return 234379;
			5:       return 117304;
			6:       return 58666;
			7:       return 29335;
			8:       return 14668;
			9:       return 7334;
			10:      return 3667;
			11:      return 1833;
			12:      return 917;
			13:      return 458;
			14:      return 229;
			15:      return 115;
			16:      return 57;
			17:      return 29;
			18:      return 14;
			19:      return 7;
			20:      return 4;
			21:      return 2;
			22:      return 1;
			default: return 0;
		endcase
	endfunction

	// Heading of one X/Y pair: axis cases first, then fold and vector
	function automatic logic [HEAD_W-1:0] heading_of(input logic [RAW_W-1:0] xr,
		input logic [RAW_W-1:0] yr);
		longint xv, yv, zv, dx, dy, t, q;
		int     i;
		xv = longint'($signed(xr));
		yv = longint'($signed(yr));
		zv = 0;
		if (yv == 0)
			return (xv < 0) ? cha_pkg::DEG_360 : cha_pkg::DEG_180;
		if (xv == 0)
			return (yv > 0) ? cha_pkg::DEG_270 : cha_pkg::DEG_90;
		xv = xv <<< 24;
		yv = yv <<< 24;
		// left half plane: rotate by +-90 into the right half
		if (xv < 0) begin
			t = xv;
			if (yv > 0) begin
				xv = yv;
				yv = -t;
				zv = 90 * DEG_ONE;
			end else begin
				xv = -yv;
				yv = t;
				zv = -90 * DEG_ONE;
			end
		end
		// vectoring: drive y to zero, hold once it is exactly zero
		for (i = 0; i < cha_pkg::CORDIC_STAGES && i < ATAN_ROWS; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv > 0) begin
				xv = xv + dx;
				yv = yv - dy;
				zv = zv + atan_q16(i);
			end else if (yv < 0) begin
				xv = xv - dx;
				yv = yv + dy;
				zv = zv - atan_q16(i);
			end
		end
		q = (zv + 180 * DEG_ONE) >>> 16;
		if (q < 0)
			q = 0;
		if (q > 359)
			q = 359;
		return q[HEAD_W-1:0];
	endfunction

	// Record accepted words, check result strobes in order
	always @(posedge clk) begin
		owed_heading_t o;
		if (!arst_n) begin
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (start && !busy) begin
				o.x       = x_raw;
				o.y       = y_raw;
				o.heading = heading_of(x_raw, y_raw);
				owed_q.push_back(o);
			end
			if (done) begin
				if (owed_q.size() == 0) begin
					$display("%0t unexpected heading word: expected none actual %0d",
						$time, heading_deg);
					mismatches <= mismatches + 1;
				end else begin
					o = owed_q.pop_front();
					if (heading_deg !== o.heading) begin
						$display("%0t heading_deg x=%h y=%h: expected %0d actual %0d",
							$time, o.x, o.y, o.heading, heading_deg);
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= owed_q.size();
		end
	end

endmodule

[tb/sv/compass_heading_atan2_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_atan2_unit_test: testbench top of the compass heading unit
// Drives directed X/Y words (axes, diagonals, extremes, near the +-180 seam)
// and then random words in bursts with random gaps; a checker beside the
// unit predicts and compares every heading. A watchdog bounds the run.
// ----------------------------------------------------------------------------
module compass_heading_atan2_unit_test;

	localparam int RAW_W        = cha_pkg::RAW_W;
	localparam int HEAD_W       = cha_pkg::HEAD_W;
	localparam int RANDOM_WORDS = 1500;
	localparam int STALL_LIMIT  = 1000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [RAW_W-1:0]    x_raw = '0;
	logic [RAW_W-1:0]    y_raw = '0;
	logic                busy;
	logic                done;
	logic [HEAD_W-1:0]   heading_deg;
	int                  mismatches;
	int                  outstanding;
	int                  burst_left = 0;
	int                  quiet_cycles = 0;

	compass_heading_atan2_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.x_raw       (x_raw),
		.y_raw       (y_raw),
		.done        (done),
		.heading_deg (heading_deg)
	);

	compass_heading_check checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.x_raw       (x_raw),
		.y_raw       (y_raw),
		.done        (done),
		.heading_deg (heading_deg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("compass_heading_atan2_unit_test: FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// One word to the unit; bursts of random length, random gaps between
	task automatic send_word(input logic [RAW_W-1:0] xv, input logic [RAW_W-1:0] yv);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		x_raw <= xv;
		y_raw <= yv;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every owed heading has come back
	task automatic drain_all();
		start <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	function automatic logic [RAW_W-1:0] tiny_word();
		return RAW_W'($urandom_range(0, 16)) - RAW_W'(8);
	endfunction

	function automatic logic [RAW_W-1:0] any_word();
		return RAW_W'($urandom());
	endfunction

	initial begin
		logic [RAW_W-1:0] xv, yv;
		int               pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: axes, diagonals, extremes, the seam near +-180
		send_word(16'h0000, 16'h0000);
		send_word(16'h7fff, 16'h0000);
		send_word(16'h8000, 16'h0000);
		send_word(16'hffff, 16'h0000);
		send_word(16'h0000, 16'h7fff);
		send_word(16'h0000, 16'h8000);
		send_word(16'h0000, 16'h0001);
		send_word(16'h0000, 16'hffff);
		send_word(16'h0001, 16'h0001);
		send_word(16'hffff, 16'hffff);
		send_word(16'hffff, 16'h0001);
		send_word(16'h0001, 16'hffff);
		send_word(16'h7fff, 16'h7fff);
		send_word(16'h8000, 16'h8000);
		send_word(16'h8000, 16'h7fff);
		send_word(16'h7fff, 16'h8000);
		send_word(16'h8000, 16'h0001);
		send_word(16'h8000, 16'hffff);
		send_word(16'h7fff, 16'h0001);
		send_word(16'h7fff, 16'hffff);
		send_word(16'h0001, 16'h7fff);
		send_word(16'h0001, 16'h8000);
		send_word(16'h5555, 16'haaaa);
		send_word(16'haaaa, 16'h5555);
		drain_all();

		// Random words of several shapes
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1, 2, 3: begin
					xv = any_word();
					yv = any_word();
				end
				4, 5: begin
					xv = tiny_word();
					yv = tiny_word();
				end
				6: begin
					// on an axis
					if ($urandom_range(0, 1)) begin
						xv = '0;
						yv = any_word();
					end else begin
						xv = any_word();
						yv = '0;
					end
				end
				7: begin
					// diagonals, both signs
					xv = any_word();
					yv = $urandom_range(0, 1) ? xv : -xv;
				end
				8: begin
					// close to the negative X axis
					xv = RAW_W'($urandom_range(16'h8000, 16'hc000));
					yv = tiny_word();
				end
				default: begin
					if ($urandom_range(0, 1)) begin
						xv = any_word();
						yv = tiny_word();
					end else begin
						xv = tiny_word();
						yv = any_word();
					end
				end
			endcase
			send_word(xv, yv);
			if (n == RANDOM_WORDS / 2)
				drain_all();
		end

		// Wait out the pipeline, then give the verdict
		drain_all();
		repeat (cha_pkg::LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("compass_heading_atan2_unit_test: PASS");
		end else begin
			$display("compass_heading_atan2_unit_test: FAIL");
		end
		$finish;
	end

endmodule
